// File: design/differential_drive_mixer_macros.svh
// assertion helpers used by ddm_cmd
`ifndef DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH
`define DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH

// same-cycle implication
`define DDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define DDM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/ddm_pkg.sv
package ddm_pkg;

    localparam logic [16:0] Q_ONE      = 17'd16384;
    localparam logic [14:0] THR_RESET  = 15'd1638;
    localparam logic [10:0] CODE_BASE  = 11'd600;
    localparam logic [8:0]  CODE_SPAN  = 9'd424;
    // reciprocal of five, exact for 16-bit dividends after a shift of 18
    localparam logic [16:0] DIV5_MUL   = 17'd52429;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_BACK = 2'd1;
    localparam logic [1:0] DIR_FWD  = 2'd2;

    typedef struct packed {
        logic               valid;
        logic               inv;
        logic               zero;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_wheel;

    typedef struct packed {
        logic        send;
        logic [10:0] lspd;
        logic [1:0]  ldir;
        logic [10:0] rspd;
        logic [1:0]  rdir;
        logic        servo;
        logic        inv;
    } t_result;

endpackage

// File: design/differential_drive_mixer.sv
// differential drive mixer: speed and turn in, per-wheel motor codes out
// input channel: i_in_valid / o_in_stall carry one speed and turn command;
//   a transfer happens on a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry exactly one result per
//   input transfer, in order; send_valid marks a fresh motor command
// config channel: i_cfg_valid / o_cfg_ready write change_threshold; ready is
//   always high, write only while no command is in flight
// stages: input register, wheel product, divide by ten,
//   compare and code register, in that order
// throughput: one command per cycle unless stalled; four-stage pipeline
// stall: while a result waits with i_out_stall high the whole pipeline holds
//   and o_in_stall is raised; otherwise every stage advances each cycle
// reset: synchronous, active low; clears the pipe, both stored wheel values
//   and sets the threshold to 1638
module differential_drive_mixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_speed_cmd,
    input  logic signed [15:0] i_turn_cmd,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [14:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_send_valid,
    output logic [10:0]        o_left_speed_code,
    output logic [1:0]         o_left_dir_code,
    output logic [10:0]        o_right_speed_code,
    output logic [1:0]         o_right_dir_code,
    output logic               o_servo_enable,
    output logic               o_invalid_cmd
);
    import ddm_pkg::*;

    logic [14:0] r_thr;
    logic        en;
    t_wheel      wheel;
    t_result     res;

    // pipeline advances unless a finished result is being held
    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // threshold register, written on a config transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // wheel mixing: abs, product, divide by ten
    ddm_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_speed_cmd (i_speed_cmd),
        .i_turn_cmd  (i_turn_cmd),
        .o_wheel     (wheel)
    );

    // stored wheel values, change detect and motor codes
    ddm_cmd u_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_wheel (wheel),
        .i_thr   (r_thr),
        .o_valid (o_out_valid),
        .o_res   (res)
    );

    assign o_send_valid       = res.send;
    assign o_left_speed_code  = res.lspd;
    assign o_left_dir_code    = res.ldir;
    assign o_right_speed_code = res.rspd;
    assign o_right_dir_code   = res.rdir;
    assign o_servo_enable     = res.servo;
    assign o_invalid_cmd      = res.inv;

endmodule

// File: design/ddm_mix.sv
module ddm_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_speed_cmd,
    input  logic signed [15:0] i_turn_cmd,
    output ddm_pkg::t_wheel    o_wheel
);
    import ddm_pkg::*;

    // stage 1: input register
    logic               r_v1;
    logic signed [15:0] r_spd;
    logic signed [15:0] r_trn;

    // stage 2: product register
    logic               r_v2;
    logic [28:0]        r_mag;
    logic               r_neg;
    logic               r_tpos;
    logic               r_tneg;
    logic               r_zero;
    logic               r_inv;
    logic signed [15:0] r_spd2;

    t_wheel r_wheel;

    logic signed [16:0] spd_x;
    logic signed [16:0] trn_x;
    logic [16:0]        spd_abs;
    logic [16:0]        trn_abs;
    logic [16:0]        trn_diff;
    logic [29:0]        prod1;
    logic [30:0]        prod2;
    logic [10:0]        q;
    logic signed [15:0] scaled;
    t_wheel             n_wheel;

    always_comb begin
        spd_x    = {r_spd[15], r_spd};
        trn_x    = {r_trn[15], r_trn};
        spd_abs  = spd_x[16] ? 17'($unsigned(-spd_x)) : 17'($unsigned(spd_x));
        trn_abs  = trn_x[16] ? 17'($unsigned(-trn_x)) : 17'($unsigned(trn_x));
        trn_diff = Q_ONE - trn_abs;
        prod1    = spd_abs[14:0] * trn_diff[14:0];
    end

    // divide by 163840: shift by 15, then multiply by the reciprocal of five
    always_comb begin
        prod2  = r_mag[28:15] * DIV5_MUL;
        q      = prod2[28:18];
        scaled = r_neg ? -$signed({5'd0, q}) : $signed({5'd0, q});
        n_wheel.valid = r_v2;
        n_wheel.inv   = r_inv;
        n_wheel.zero  = r_zero;
        n_wheel.left  = r_tneg ? scaled : r_spd2;
        n_wheel.right = r_tpos ? scaled : r_spd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_wheel.valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_wheel <= n_wheel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spd  <= i_speed_cmd;
            r_trn  <= i_turn_cmd;
            r_mag  <= prod1[28:0];
            r_neg  <= r_spd[15];
            r_tpos <= !r_trn[15] && (r_trn != 16'sd0);
            r_tneg <= r_trn[15];
            r_zero <= (r_spd == 16'sd0);
            r_inv  <= (spd_abs > Q_ONE) || (trn_abs > Q_ONE);
            r_spd2 <= r_spd;
        end
    end

    assign o_wheel = r_wheel;

endmodule

// File: design/ddm_cmd.sv
`include "differential_drive_mixer_macros.svh"

module ddm_cmd (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  ddm_pkg::t_wheel  i_wheel,
    input  logic [14:0]      i_thr,
    output logic             o_valid,
    output ddm_pkg::t_result o_res
);
    import ddm_pkg::*;

    logic signed [15:0] r_pl;
    logic signed [15:0] r_pr;
    logic               r_valid;
    t_result            r_res;

    logic               stop;
    logic signed [16:0] dl;
    logic signed [16:0] dr;
    logic [16:0]        dl_abs;
    logic [16:0]        dr_abs;
    logic               chg;
    t_result            n_res;

    function automatic logic [10:0] speed_code(input logic signed [15:0] w);
        logic [15:0] wabs;
        logic [23:0] prod;
        wabs = w[15] ? 16'($unsigned(-w)) : 16'($unsigned(w));
        prod = wabs[14:0] * CODE_SPAN;
        return CODE_BASE + {1'b0, prod[23:14]};
    endfunction

    function automatic logic [1:0] dir_code(input logic signed [15:0] w);
        logic [1:0] d;
        if (w[15]) begin
            d = DIR_BACK;
        end else if (w != 16'sd0) begin
            d = DIR_FWD;
        end else begin
            d = DIR_STOP;
        end
        return d;
    endfunction

    always_comb begin
        stop   = i_wheel.zero && (r_pl != 16'sd0) && (r_pr != 16'sd0);
        dl     = {r_pl[15], r_pl} - {i_wheel.left[15], i_wheel.left};
        dr     = {r_pr[15], r_pr} - {i_wheel.right[15], i_wheel.right};
        dl_abs = dl[16] ? 17'($unsigned(-dl)) : 17'($unsigned(dl));
        dr_abs = dr[16] ? 17'($unsigned(-dr)) : 17'($unsigned(dr));
        chg    = (dl_abs >= {2'd0, i_thr}) || (dr_abs >= {2'd0, i_thr});

        n_res = '0;
        priority if (stop) begin
            n_res.send  = 1'b1;
            n_res.servo = 1'b1;
        end else if (i_wheel.inv) begin
            n_res.inv = 1'b1;
        end else if (chg) begin
            n_res.send = 1'b1;
            n_res.lspd = speed_code(i_wheel.left);
            n_res.ldir = dir_code(i_wheel.left);
            n_res.rspd = speed_code(i_wheel.right);
            n_res.rdir = dir_code(i_wheel.right);
        end else begin
            // change below threshold, all fields stay zero
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pl    <= 16'sd0;
            r_pr    <= 16'sd0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_wheel.valid;
            if (i_wheel.valid) begin
                priority if (stop) begin
                    r_pl <= 16'sd0;
                    r_pr <= 16'sd0;
                end else if (!i_wheel.inv && chg) begin
                    r_pl <= i_wheel.left;
                    r_pr <= i_wheel.right;
                end else begin
                    // stored wheel values hold
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    `DDM_ASSERT_NXT(a_stop_clears, i_clk, i_rst_n, i_en && i_wheel.valid && stop,
        r_pl == 16'sd0 && r_pr == 16'sd0)
    `DDM_ASSERT_NXT(a_inv_holds, i_clk, i_rst_n, i_en && i_wheel.valid && !stop && i_wheel.inv,
        $stable(r_pl) && $stable(r_pr))
    `DDM_ASSERT_IMP(a_servo_stop, i_clk, i_rst_n, r_valid && r_res.servo,
        r_res.send && r_res.lspd == 11'd0 && r_res.rspd == 11'd0 && !r_res.inv)

endmodule

// File: tb/sv/tb.sv
module tb;
    import ddm_pkg::*;

    // wheel arithmetic is done in plain ints; Q2.14 unit and code constants
    localparam int UNIT      = int'(Q_ONE);
    localparam int BASE_CODE = int'(CODE_BASE);
    localparam int SPAN_CODE = int'(CODE_SPAN);
    localparam int IDLE_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 175;

    // directed commands: extremes, both turn signs, full stop, invalid, small change
    localparam int PLAN_SPEED [23] = '{
        0, 16384, 16384, 0, 16384, 0, -16384, -16384, -16384, 0, 16385, -16385,
        0, -32768, 32767, 16384, 16000, 1, -1, 16384, 8192, 0, 0};
    localparam int PLAN_TURN [23] = '{
        0, 0, 16384, 0, 0, 32767, 0, -16384, 8192, -32768, 0, 0,
        16385, -32768, 32767, -1, -1, 1, -1, 16383, -16384, 0, 0};
    localparam int CORNER_VALUES [9] = '{
        -32768, -16385, -16384, -1, 0, 1, 16384, 16385, 32767};

    // mirrors the mixer: stored wheels, threshold, and the results still owed
    class mixer_scoreboard;
        int      threshold;
        int      held_left;
        int      held_right;
        t_result owed [$];
        int      mismatches;
        int      checked;
        int      sends;
        int      stops;
        int      invalids;

        function new();
            threshold  = int'(THR_RESET);
            held_left  = 0;
            held_right = 0;
            mismatches = 0;
            checked    = 0;
            sends      = 0;
            stops      = 0;
            invalids   = 0;
        endfunction

        function int mag(int v);
            return (v < 0) ? -v : v;
        endfunction

        function logic [10:0] code_of(int w);
            return 11'(BASE_CODE + (mag(w) * SPAN_CODE) / UNIT);
        endfunction

        function logic [1:0] dir_of(int w);
            if (w > 0) begin
                return DIR_FWD;
            end else if (w < 0) begin
                return DIR_BACK;
            end
            return DIR_STOP;
        endfunction

        function void set_threshold(logic [14:0] v);
            threshold = int'(v);
        endfunction

        function void note_input(logic signed [15:0] spd, logic signed [15:0] trn);
            int      s;
            int      t;
            int      q;
            int      lw;
            int      rw;
            t_result r;
            s = spd;
            t = trn;
            r = '0;
            if (s == 0 && held_left != 0 && held_right != 0) begin
                // full stop, turn is not looked at
                held_left  = 0;
                held_right = 0;
                r.send     = 1'b1;
                r.servo    = 1'b1;
                stops++;
            end else if (mag(s) > UNIT || mag(t) > UNIT) begin
                r.inv = 1'b1;
                invalids++;
            end else begin
                lw = s;
                rw = s;
                q  = (mag(s) * (UNIT - mag(t))) / (UNIT * 10);
                if (s < 0) begin
                    q = -q;
                end
                if (t > 0) begin
                    rw = q;
                end else if (t < 0) begin
                    lw = q;
                end
                if (mag(held_left - lw) >= threshold || mag(held_right - rw) >= threshold) begin
                    held_left  = lw;
                    held_right = rw;
                    r.send     = 1'b1;
                    r.lspd     = code_of(lw);
                    r.ldir     = dir_of(lw);
                    r.rspd     = code_of(rw);
                    r.rdir     = dir_of(rw);
                    sends++;
                end
            end
            owed.push_back(r);
        endfunction

        function void flag(string what, logic [10:0] want, logic [10:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at result %0d, %s: expected %0d, got %0d",
                         checked, what, want, got);
            end
        endfunction

        function void field(string what, logic [10:0] want, logic [10:0] got);
            if (want !== got) begin
                flag(what, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                flag("result with no command waiting", 11'd0, 11'd1);
                return;
            end
            want = owed.pop_front();
            checked++;
            field("send_valid", want.send, got.send);
            field("left_speed_code", want.lspd, got.lspd);
            field("left_dir_code", want.ldir, got.ldir);
            field("right_speed_code", want.rspd, got.rspd);
            field("right_dir_code", want.rdir, got.rdir);
            field("servo_enable", want.servo, got.servo);
            field("invalid_cmd", want.inv, got.inv);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_speed_cmd;
    logic signed [15:0] i_turn_cmd;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [14:0]        i_cfg_data;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_send_valid;
    logic [10:0]        o_left_speed_code;
    logic [1:0]         o_left_dir_code;
    logic [10:0]        o_right_speed_code;
    logic [1:0]         o_right_dir_code;
    logic               o_servo_enable;
    logic               o_invalid_cmd;

    mixer_scoreboard sb;
    int sender_idle_pct = 30;
    int stall_pct       = 84;
    int last_spd        = 0;
    int last_trn        = 0;
    int driven          = 0;
    int idle_cycles     = 0;

    differential_drive_mixer u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_speed_cmd        (i_speed_cmd),
        .i_turn_cmd         (i_turn_cmd),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_send_valid       (o_send_valid),
        .o_left_speed_code  (o_left_speed_code),
        .o_left_dir_code    (o_left_dir_code),
        .o_right_speed_code (o_right_speed_code),
        .o_right_dir_code   (o_right_dir_code),
        .o_servo_enable     (o_servo_enable),
        .o_invalid_cmd      (o_invalid_cmd)
    );

    always #10 i_clk = ~i_clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result side: sampled values are the ones from before the edge
    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen.send  = o_send_valid;
            seen.lspd  = o_left_speed_code;
            seen.ldir  = o_left_dir_code;
            seen.rspd  = o_right_speed_code;
            seen.rdir  = o_right_dir_code;
            seen.servo = o_servo_enable;
            seen.inv   = o_invalid_cmd;
            sb.check_result(seen);
        end
    end

    // watchdog: any transfer on any channel clears the count
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still owed",
                     IDLE_LIMIT, sb.owed.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // one command transfer; valid stays high into the next call when there is no gap
    task automatic send_cmd(input int spd, input int trn);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_speed_cmd <= 16'(spd);
        i_turn_cmd  <= 16'(trn);
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(16'(spd), 16'(trn));
        last_spd = spd;
        last_trn = trn;
        driven++;
    endtask

    // sender holds off until every owed result is out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed.size() != 0);
    endtask

    task automatic write_threshold(input logic [14:0] v);
        drain();
        // let the pipe settle past its four stages
        repeat (6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.set_threshold(v);
    endtask

    // mostly in-range commands, with stops, small steps, noise and corners mixed in
    task automatic random_cmd();
        int s;
        int t;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            s = $urandom_range(0, 2 * UNIT) - UNIT;
            t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2 * UNIT) - UNIT;
        end else if (pick < 70) begin
            // zero speed: full stop when both wheels are running, turn unchecked
            s = 0;
            t = int'($signed(16'($urandom())));
        end else if (pick < 82) begin
            // small step from the last command, exercises the threshold
            s = last_spd + int'($urandom_range(0, 4000)) - 2000;
            if (s > UNIT) begin
                s = UNIT;
            end else if (s < -UNIT) begin
                s = -UNIT;
            end
            t = (last_trn > UNIT || last_trn < -UNIT) ? 0 : last_trn;
        end else if (pick < 94) begin
            s = int'($signed(16'($urandom())));
            t = int'($signed(16'($urandom())));
        end else begin
            s = CORNER_VALUES[$urandom_range(0, 8)];
            t = CORNER_VALUES[$urandom_range(0, 8)];
        end
        send_cmd(s, t);
    endtask

    initial begin
        int phase;
        int n;
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_speed_cmd <= '0;
        i_turn_cmd  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_out_stall <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < 23; n++) begin
            send_cmd(PLAN_SPEED[n], PLAN_TURN[n]);
        end

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                1: write_threshold(15'd0);
                2: write_threshold(15'h7fff);
                3: write_threshold(15'($urandom_range(1, 4000)));
                4: write_threshold(15'd1);
                5: write_threshold(THR_RESET);
                default: ;
            endcase
            // idling profile: sender light and receiver heavy, then swapped, then none
            if (phase < 2) begin
                sender_idle_pct = 30;
                stall_pct       = 84;
            end else if (phase < 4) begin
                sender_idle_pct = 84;
                stall_pct       = 30;
            end else begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    drain();
                end
                random_cmd();
            end
        end

        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("drove %0d commands over thresholds 1638, 0, 32767, random, 1 and 1638",
                 driven);
        $display("checked %0d results: %0d motor commands, %0d full stops, %0d invalid",
                 sb.checked, sb.sends, sb.stops, sb.invalids);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.owed.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/ddm_pkg.sv
design/ddm_mix.sv
design/ddm_cmd.sv
design/differential_drive_mixer.sv
tb/sv/tb.sv
